// ===== rtl/bclp_pkg.sv =====
package bclp_pkg;

	localparam int NUM_BUTTONS_DEF = 3;
	localparam int TIME_WIDTH_DEF  = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam int CFG_WIDTH  = 16;
	localparam int ADDR_WIDTH = 2;

	// operation codes of an input item
	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_POLL    = 2'd2;

	// configuration register indexes
	localparam logic [ADDR_WIDTH-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [ADDR_WIDTH-1:0] REG_CLICK_MAX = 2'd1;
	localparam logic [ADDR_WIDTH-1:0] REG_LONG_MIN  = 2'd2;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST  = 16'd30;
	localparam logic [CFG_WIDTH-1:0] CLICK_MAX_RST = 16'd700;
	localparam logic [CFG_WIDTH-1:0] LONG_MIN_RST  = 16'd1200;

	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  button;
		logic [31:0] time_ms;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic        confirm_held;
		logic [31:0] confirm_hold_ms;
	} result_t;

	typedef enum logic [1:0] {
		CMD_PRESS   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_POLL    = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [1:0]  button;
		logic [31:0] time_ms;
	} cmd_t;

endpackage

// ===== rtl/button_click_long_press_classifier.sv =====
// Click / long-press classifier for NUM_BUTTONS buttons (0 confirm, 1 up,
// 2 down). Push press edges, release edges and polls, each stamped with a
// free-running millisecond time; every poll yields exactly one result (event
// code, confirm held flag and hold time), edges and unused opcodes yield none.
// Throughput is one item per clock while full is low: the front decodes and
// drops ignored items into a two-entry command queue, the back retires one
// command per cycle unless a poll waits on a full result queue, with all
// per-button checks done in parallel; results wait in a two-entry result
// queue. A poll passes the command queue, then the result queue, to the ports.
// full rises only when the command queue fills, which happens only while pop
// is held off and polls back up.
// Configuration writes are registered; write only while the block is idle.
// No clearing pass after reset: the block takes items right away.
module button_click_long_press_classifier #(
	parameter int NUM_BUTTONS = bclp_pkg::NUM_BUTTONS_DEF,
	parameter int TIME_WIDTH  = bclp_pkg::TIME_WIDTH_DEF,
	parameter int QUEUE_DEPTH = bclp_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input side
	input  logic                            push,
	output logic                            full,
	input  bclp_pkg::item_t                 item,
	// result side
	output logic                            empty,
	input  logic                            pop,
	output bclp_pkg::result_t               result,
	// configuration writes
	input  logic                            cfg_wr,
	input  logic [bclp_pkg::ADDR_WIDTH-1:0] cfg_addr,
	input  logic [bclp_pkg::CFG_WIDTH-1:0]  cfg_wdata
);

	logic              cmd_wr;
	logic              cmd_full;
	logic              cmd_rd;
	logic              cmd_empty;
	bclp_pkg::cmd_t    cmd_in;
	bclp_pkg::cmd_t    cmd_out;
	logic              res_wr;
	logic              res_full;
	bclp_pkg::result_t res_in;

	// front: decode and filter each transfer in
	bclp_front #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_front (
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_wr   (cmd_wr),
		.cmd      (cmd_in)
	);

	// command queue decouples the front from a stalled back
	bclp_fifo #(
		.T     (bclp_pkg::cmd_t),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_rd),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// back: per-button state, config registers, poll evaluation
	bclp_back #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_rd    (cmd_rd),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res       (res_in),
		.cfg_wr    (cfg_wr),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// result queue: oldest result sits on the outputs while empty is low
	bclp_fifo #(
		.T     (bclp_pkg::result_t),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_in),
		.full   (res_full),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

// ===== rtl/bclp_fifo.sv =====
module bclp_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = bclp_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  T     wdata,
	output logic full,
	input  logic rd,
	output T     rdata,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	T              mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bclp_front.sv =====
module bclp_front #(
	parameter int NUM_BUTTONS = bclp_pkg::NUM_BUTTONS_DEF
) (
	input  logic            push,
	input  bclp_pkg::item_t item,
	output logic            full,
	input  logic            cmd_full,
	output logic            cmd_wr,
	output bclp_pkg::cmd_t  cmd
);

	logic keep;
	logic btn_ok;

	// edges on buttons that do not exist and the unused opcode are dropped here
	assign btn_ok = (32'(item.button) < NUM_BUTTONS);
	assign full   = cmd_full;

	always_comb begin
		keep         = 1'b0;
		cmd.kind     = bclp_pkg::CMD_POLL;
		cmd.button   = item.button;
		cmd.time_ms  = item.time_ms;
		unique case (item.operation)
			bclp_pkg::OP_PRESS: begin
				keep     = btn_ok;
				cmd.kind = bclp_pkg::CMD_PRESS;
			end
			bclp_pkg::OP_RELEASE: begin
				keep     = btn_ok;
				cmd.kind = bclp_pkg::CMD_RELEASE;
			end
			bclp_pkg::OP_POLL: begin
				keep     = 1'b1;
				cmd.kind = bclp_pkg::CMD_POLL;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign cmd_wr = push && !cmd_full && keep;

endmodule

// ===== rtl/bclp_back.sv =====
module bclp_back #(
	parameter int NUM_BUTTONS = bclp_pkg::NUM_BUTTONS_DEF,
	parameter int TIME_WIDTH  = bclp_pkg::TIME_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_empty,
	input  bclp_pkg::cmd_t                      cmd,
	output logic                                cmd_rd,
	input  logic                                res_full,
	output logic                                res_wr,
	output bclp_pkg::result_t                   res,
	input  logic                                cfg_wr,
	input  logic [bclp_pkg::ADDR_WIDTH-1:0]     cfg_addr,
	input  logic [bclp_pkg::CFG_WIDTH-1:0]      cfg_wdata
);

	logic [bclp_pkg::CFG_WIDTH-1:0] debounce_q;
	logic [bclp_pkg::CFG_WIDTH-1:0] click_max_q;
	logic [bclp_pkg::CFG_WIDTH-1:0] long_min_q;

	logic [TIME_WIDTH-1:0] press_time_q   [NUM_BUTTONS];
	logic [TIME_WIDTH-1:0] release_time_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] press_valid_q;
	logic [NUM_BUTTONS-1:0] release_valid_q;
	logic [NUM_BUTTONS-1:0] long_done_q;

	logic [TIME_WIDTH-1:0]  now;
	logic [TIME_WIDTH-1:0]  since_press [NUM_BUTTONS];
	logic [TIME_WIDTH-1:0]  held_for    [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] sel;
	logic [NUM_BUTTONS-1:0] long_fire;
	logic [NUM_BUTTONS-1:0] pair;
	logic [NUM_BUTTONS-1:0] click_fire;
	logic [NUM_BUTTONS-1:0] examined;
	logic [NUM_BUTTONS-1:0] first_fire;
	logic [2:0]             code;
	logic                   found;
	logic                   take;
	logic                   is_poll;
	logic                   held;

	assign now     = TIME_WIDTH'(cmd.time_ms);
	assign is_poll = (cmd.kind == bclp_pkg::CMD_POLL);
	// edges never stall on the result side
	assign take    = !cmd_empty && (!is_poll || !res_full);
	assign cmd_rd  = take;
	assign res_wr  = take && is_poll;

	always_comb begin
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			sel[k]         = (32'(cmd.button) == k);
			since_press[k] = now - press_time_q[k];
			held_for[k]    = release_time_q[k] - press_time_q[k];
			long_fire[k]   = press_valid_q[k] && !release_valid_q[k] && !long_done_q[k]
				&& (since_press[k] >= TIME_WIDTH'(long_min_q));
			pair[k]        = press_valid_q[k] && release_valid_q[k];
			click_fire[k]  = pair[k] && !long_done_q[k]
				&& (held_for[k] >= TIME_WIDTH'(debounce_q))
				&& (held_for[k] <= TIME_WIDTH'(click_max_q));
		end
	end

	// buttons are checked in index order; the walk stops at the first event
	always_comb begin
		found      = 1'b0;
		code       = '0;
		examined   = '0;
		first_fire = '0;
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			examined[k] = !found;
			if (!found && (long_fire[k] || click_fire[k])) begin
				found         = 1'b1;
				first_fire[k] = 1'b1;
				code          = 3'(2 * k + (long_fire[k] ? 2 : 1));
			end
		end
	end

	// a stored pair on confirm leaves it not held either way
	assign held                = press_valid_q[0] && !release_valid_q[0];
	assign res.event_code      = code;
	assign res.confirm_held    = held;
	assign res.confirm_hold_ms = held ? 32'(since_press[0]) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= bclp_pkg::DEBOUNCE_RST;
			click_max_q <= bclp_pkg::CLICK_MAX_RST;
			long_min_q  <= bclp_pkg::LONG_MIN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_addr)
				bclp_pkg::REG_DEBOUNCE:  debounce_q  <= cfg_wdata;
				bclp_pkg::REG_CLICK_MAX: click_max_q <= cfg_wdata;
				bclp_pkg::REG_LONG_MIN:  long_min_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_valid_q   <= '0;
			release_valid_q <= '0;
			long_done_q     <= '0;
		end else if (take) begin
			for (int k = 0; k < NUM_BUTTONS; k++) begin
				case (cmd.kind)
					bclp_pkg::CMD_PRESS: begin
						if (sel[k]) begin
							press_valid_q[k]   <= 1'b1;
							release_valid_q[k] <= 1'b0;
							long_done_q[k]     <= 1'b0;
						end
					end
					bclp_pkg::CMD_RELEASE: begin
						if (sel[k]) begin
							release_valid_q[k] <= 1'b1;
						end
					end
					default: begin
						if (examined[k] && pair[k]) begin
							press_valid_q[k]   <= 1'b0;
							release_valid_q[k] <= 1'b0;
						end
						if (examined[k] && long_fire[k]) begin
							long_done_q[k] <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < NUM_BUTTONS; k++) begin
				if (sel[k] && cmd.kind == bclp_pkg::CMD_PRESS) begin
					press_time_q[k] <= now;
				end
				if (sel[k] && cmd.kind == bclp_pkg::CMD_RELEASE) begin
					release_time_q[k] <= now;
				end
			end
		end
	end

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> !res_full)
		else $error("result written into a full queue");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_fire))
		else $error("more than one button reported in one poll");

	a_code_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr && (res.event_code != 3'd0) |-> (first_fire != '0))
		else $error("event reported with no firing button");

	a_press_arms: assert property (@(posedge clk) disable iff (!arst_n)
		take && (cmd.kind == bclp_pkg::CMD_PRESS) && sel[0]
		|=> press_valid_q[0] && !release_valid_q[0] && !long_done_q[0])
		else $error("confirm press did not arm its state");

	a_long_once: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_poll && long_fire[0] && first_fire[0] |=> long_done_q[0])
		else $error("long press on confirm not recorded");

endmodule
